[sv/bde_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bde_pkg
// Shared types and constants of the bitmap draw engine.
// ----------------------------------------------------------------------------
package bde_pkg;

    // coordinate and accumulator widths
    localparam int CW = 10;
    localparam int AW = 20;

    // command codes
    localparam logic [3:0] CMD_PLOT      = 4'd0;
    localparam logic [3:0] CMD_LINE      = 4'd1;
    localparam logic [3:0] CMD_TRIANGLE  = 4'd2;
    localparam logic [3:0] CMD_RECT      = 4'd3;
    localparam logic [3:0] CMD_CIRCLE    = 4'd4;
    localparam logic [3:0] CMD_CLR_RECT  = 4'd5;
    localparam logic [3:0] CMD_CLR_ALL   = 4'd6;
    localparam logic [3:0] CMD_SHIFT     = 4'd7;
    localparam logic [3:0] CMD_MIRROR    = 4'd8;
    localparam logic [3:0] CMD_READ      = 4'd9;

    // configuration register indexes
    localparam logic REG_ACTIVE_WIDTH  = 1'b0;
    localparam logic REG_ACTIVE_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LINES,
        OP_CIRCLE,
        OP_CLR_RECT,
        OP_CLR_ALL,
        OP_REMAP,
        OP_READ
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MODW,
        ST_ROW_RD,
        ST_ROW_LD,
        ST_PIX,
        ST_ROW_WR,
        ST_DONE
    } st_t;

    // classified command as it sits in the queue
    typedef struct packed {
        op_t               op;
        logic [3:0]        cmd;
        logic [1:0]        nl_last;
        logic              is_mirror;
        logic [1:0]        flip;
        logic signed [7:0] xa;
        logic signed [7:0] ya;
        logic signed [7:0] xb;
        logic signed [7:0] yb;
        logic signed [7:0] xc;
        logic signed [7:0] yc;
        logic [6:0]        radius;
    } job_t;

    // one line segment
    typedef struct packed {
        logic signed [7:0] x1;
        logic signed [7:0] y1;
        logic signed [7:0] x2;
        logic signed [7:0] y2;
    } seg_t;

endpackage

[sv/bde_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bde_ifs
// Channel interfaces: command input, result output and register writes.
// ----------------------------------------------------------------------------
interface bde_cmd_if;
    logic              valid;
    logic              ready;
    logic [3:0]        cmd;
    logic signed [7:0] x_a;
    logic signed [7:0] y_a;
    logic signed [7:0] x_b;
    logic signed [7:0] y_b;
    logic signed [7:0] x_c;
    logic signed [7:0] y_c;
    logic [6:0]        radius;
    logic [1:0]        flip_axes;

    modport source (output valid, cmd, x_a, y_a, x_b, y_b, x_c, y_c, radius, flip_axes,
                    input ready);
    modport sink (input valid, cmd, x_a, y_a, x_b, y_b, x_c, y_c, radius, flip_axes,
                  output ready);
endinterface

interface bde_res_if;
    logic       valid;
    logic       ready;
    logic       pixel_on;
    logic [3:0] cmd_done;

    modport source (output valid, pixel_on, cmd_done, input ready);
    modport sink (input valid, pixel_on, cmd_done, output ready);
endinterface

interface bde_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[sv/bde_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bde_front
// Accepts commands and classifies them into queue entries.
// ----------------------------------------------------------------------------
module bde_front
    import bde_pkg::*;
(
    input  logic      q_full,
    bde_cmd_if.sink   cmds,
    output logic      push,
    output job_t      job
);

    assign cmds.ready = !q_full;
    assign push       = cmds.valid && !q_full;

    // classify the command
    always_comb
    begin
        job           = '0;
        job.op        = OP_NOP;
        job.cmd       = cmds.cmd;
        job.flip      = cmds.flip_axes;
        job.xa        = cmds.x_a;
        job.ya        = cmds.y_a;
        job.xb        = cmds.x_b;
        job.yb        = cmds.y_b;
        job.xc        = cmds.x_c;
        job.yc        = cmds.y_c;
        job.radius    = cmds.radius;
        case (cmds.cmd)
            CMD_PLOT:
            begin
                job.op = OP_LINES;
                job.xb = cmds.x_a;
                job.yb = cmds.y_a;
            end
            CMD_LINE:     job.op = OP_LINES;
            CMD_TRIANGLE:
            begin
                job.op      = OP_LINES;
                job.nl_last = 2'd2;
            end
            CMD_RECT:
            begin
                job.op      = OP_LINES;
                job.nl_last = 2'd3;
            end
            CMD_CIRCLE:   job.op = OP_CIRCLE;
            CMD_CLR_RECT:
            begin
                // order the corners
                job.op = OP_CLR_RECT;
                job.xa = (cmds.x_a < cmds.x_b) ? cmds.x_a : cmds.x_b;
                job.xb = (cmds.x_a < cmds.x_b) ? cmds.x_b : cmds.x_a;
                job.ya = (cmds.y_a < cmds.y_b) ? cmds.y_a : cmds.y_b;
                job.yb = (cmds.y_a < cmds.y_b) ? cmds.y_b : cmds.y_a;
            end
            CMD_CLR_ALL:  job.op = OP_CLR_ALL;
            CMD_SHIFT:    job.op = OP_REMAP;
            CMD_MIRROR:
            begin
                job.op        = (cmds.flip_axes == 2'b00) ? OP_NOP : OP_REMAP;
                job.is_mirror = 1'b1;
            end
            CMD_READ:     job.op = OP_READ;
            default:      job.op = OP_NOP;
        endcase
    end

endmodule

[sv/bde_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bde_queue
// Two-entry queue of classified commands between front and back.
// ----------------------------------------------------------------------------
module bde_queue
    import bde_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    output logic full,
    input  logic pop,
    output logic empty,
    output job_t head
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

[sv/bde_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bde_back
// Executes queued commands row by row, one pixel per cycle, on the row store.
// ----------------------------------------------------------------------------
module bde_back
    import bde_pkg::*;
#(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 64
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  job_t                          q_head,
    output logic                          pop,
    input  logic [$clog2(MAX_WIDTH):0]    w_eff,
    input  logic [$clog2(MAX_HEIGHT):0]   h_eff,
    bde_res_if.source                     results
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);

    // row store and remap scratch rows
    logic [MAX_WIDTH-1:0] pix_mem [MAX_HEIGHT];
    logic [MAX_WIDTH-1:0] tmp_mem [MAX_HEIGHT];
    logic [MAX_WIDTH-1:0] pix_q;
    logic [MAX_WIDTH-1:0] tmp_q;
    logic [MAX_HEIGHT-1:0] row_valid_reg;
    logic                 valid_q;

    st_t                  state_reg, state_next;
    job_t                 job_reg, job_next;
    logic [1:0]           line_idx_reg, line_idx_next;
    logic [1:0]           cnt_reg, cnt_next;
    logic                 merge_reg, merge_next;
    logic [YW-1:0]        y_reg, y_next;
    logic [XW-1:0]        x_reg, x_next;
    logic [XW-1:0]        xd_reg, xd_next;
    logic [XW-1:0]        xs_reg, xs_next;
    logic [YW-1:0]        yd_reg, yd_next;
    logic [MAX_WIDTH-1:0] rbuf_reg, rbuf_next;
    logic [MAX_WIDTH-1:0] obuf_reg, obuf_next;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic signed [AW-1:0] accr_reg, accr_next;
    logic signed [AW-1:0] m0_reg, m0_next;
    logic signed [AW-1:0] m1_reg, m1_next;
    logic signed [AW-1:0] m2_reg, m2_next;
    seg_t                 seg_reg, seg_next;
    logic signed [CW-1:0] mx_reg, mx_next;
    logic signed [CW-1:0] my_reg, my_next;
    logic                 pon_reg, pon_next;
    logic                 res_valid_reg, res_valid_next;
    logic                 res_pon_reg, res_pon_next;
    logic [3:0]           res_cmd_reg, res_cmd_next;
    logic                 pix_we;
    logic                 tmp_we;
    logic                 clr_all;

    // derived values
    logic signed [CW-1:0] w_s, h_s, xs, ys;
    logic signed [CW-1:0] x1, y1, x2, y2, dx, dy, adx, ady;
    logic signed [CW-1:0] xl, xh, yl, yh;
    logic signed [CW-1:0] cx, cy;
    logic signed [CW-1:0] ma, mb;
    logic signed [AW-1:0] prod;
    logic signed [AW:0]   s2, sv, lim;
    logic signed [AW-1:0] rad;
    logic [XW-1:0]        w_m1;
    logic [YW-1:0]        h_m1;
    logic [MAX_WIDTH-1:0] row_in;
    logic                 line_hit, circ_hit, rect_in, in_box, degen, majx;
    logic                 dir_x, dir_y, mod_ok, rd_ok, last_x, last_y, out_free;

    // segment of the current line within a multi-line shape
    function automatic seg_t line_sel(input job_t j, input logic [1:0] idx);
        seg_t s;
        s = '{j.xa, j.ya, j.xb, j.yb};
        if (j.cmd == CMD_TRIANGLE)
        begin
            case (idx)
                2'd1:    s = '{j.xa, j.ya, j.xc, j.yc};
                2'd2:    s = '{j.xb, j.yb, j.xc, j.yc};
                default: s = '{j.xa, j.ya, j.xb, j.yb};
            endcase
        end
        else if (j.cmd == CMD_RECT)
        begin
            case (idx)
                2'd0:    s = '{j.xa, j.ya, j.xa, j.yb};
                2'd1:    s = '{j.xa, j.ya, j.xb, j.ya};
                2'd2:    s = '{j.xa, j.yb, j.xb, j.yb};
                default: s = '{j.xb, j.ya, j.xb, j.yb};
            endcase
        end
        return s;
    endfunction

    assign w_s  = $signed(CW'(w_eff));
    assign h_s  = $signed(CW'(h_eff));
    assign xs   = $signed(CW'(x_reg));
    assign ys   = $signed(CW'(y_reg));
    assign w_m1 = XW'(w_eff - 1'b1);
    assign h_m1 = YW'(h_eff - 1'b1);
    assign last_x = (x_reg == w_m1);
    assign last_y = (y_reg == h_m1);
    assign out_free = !res_valid_reg || results.ready;

    // line geometry
    assign x1   = CW'(seg_reg.x1);
    assign y1   = CW'(seg_reg.y1);
    assign x2   = CW'(seg_reg.x2);
    assign y2   = CW'(seg_reg.y2);
    assign dx   = x2 - x1;
    assign dy   = y2 - y1;
    assign adx  = dx[CW-1] ? -dx : dx;
    assign ady  = dy[CW-1] ? -dy : dy;
    assign xl   = (x1 < x2) ? x1 : x2;
    assign xh   = (x1 < x2) ? x2 : x1;
    assign yl   = (y1 < y2) ? y1 : y2;
    assign yh   = (y1 < y2) ? y2 : y1;
    assign degen = (dx == '0) && (dy == '0);
    assign majx = (adx >= ady);
    assign in_box = (xs >= xl) && (xs <= xh) && (ys >= yl) && (ys <= yh);
    assign s2   = {acc_reg, 1'b0};
    assign sv   = majx ? (dx[CW-1] ? -s2 : s2) : (dy[CW-1] ? s2 : -s2);
    assign lim  = (AW + 1)'(majx ? adx : ady);
    assign line_hit = in_box && (degen || ((sv >= -lim) && (sv < lim)));

    // circle ring and clear box
    assign cx  = CW'(job_reg.xa);
    assign cy  = CW'(job_reg.ya);
    assign rad = $signed(AW'(job_reg.radius));
    assign circ_hit = ((job_reg.radius == '0) || (acc_reg > (m2_reg - rad)))
                      && (acc_reg <= (m2_reg + rad));
    assign rect_in = (xs >= CW'(job_reg.xa)) && (xs <= CW'(job_reg.xb))
                     && (ys >= CW'(job_reg.ya)) && (ys <= CW'(job_reg.yb));

    assign dir_x  = job_reg.is_mirror && job_reg.flip[0];
    assign dir_y  = job_reg.is_mirror && job_reg.flip[1];
    assign mod_ok = (mx_reg >= 0) && (mx_reg < w_s) && (my_reg >= 0) && (my_reg < h_s);
    assign rd_ok  = (cx >= 0) && (cx < w_s) && (cy >= 0) && (cy < h_s);
    assign row_in = valid_q ? pix_q : '0;

    // setup multiplier
    always_comb
    begin
        ma = CW'(job_reg.radius);
        mb = CW'(job_reg.radius);
        if (cnt_reg == 2'd1)
        begin
            ma = (job_reg.op == OP_LINES) ? x1 : cx;
            mb = (job_reg.op == OP_LINES) ? dy : cx;
        end
        else if (cnt_reg == 2'd2)
        begin
            ma = (job_reg.op == OP_LINES) ? y1 : cy;
            mb = (job_reg.op == OP_LINES) ? dx : cy;
        end
    end
    assign prod = ma * mb;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (!q_empty)
                    state_next = ST_SETUP;
            ST_SETUP:
                if (cnt_reg == 2'd3)
                begin
                    case (job_reg.op)
                        OP_NOP, OP_CLR_ALL: state_next = ST_DONE;
                        OP_READ:            state_next = rd_ok ? ST_ROW_RD : ST_DONE;
                        OP_REMAP:           state_next = ST_MODW;
                        default:            state_next = ST_ROW_RD;
                    endcase
                end
            ST_MODW:
                if (mod_ok)
                    state_next = ST_ROW_RD;
            ST_ROW_RD:
                state_next = ST_ROW_LD;
            ST_ROW_LD:
                if (job_reg.op == OP_READ)
                    state_next = ST_DONE;
                else if (merge_reg)
                    state_next = ST_ROW_WR;
                else
                    state_next = ST_PIX;
            ST_PIX:
                if (last_x)
                    state_next = ST_ROW_WR;
            ST_ROW_WR:
                if (!last_y)
                    state_next = ST_ROW_RD;
                else if (job_reg.op == OP_LINES && line_idx_reg != job_reg.nl_last)
                    state_next = ST_SETUP;
                else if (job_reg.op == OP_REMAP && !merge_reg)
                    state_next = ST_ROW_RD;
                else
                    state_next = ST_DONE;
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        job_next       = job_reg;
        line_idx_next  = line_idx_reg;
        cnt_next       = cnt_reg;
        merge_next     = merge_reg;
        y_next         = y_reg;
        x_next         = x_reg;
        xd_next        = xd_reg;
        xs_next        = xs_reg;
        yd_next        = yd_reg;
        rbuf_next      = rbuf_reg;
        obuf_next      = obuf_reg;
        acc_next       = acc_reg;
        accr_next      = accr_reg;
        m0_next        = m0_reg;
        m1_next        = m1_reg;
        m2_next        = m2_reg;
        seg_next       = seg_reg;
        mx_next        = mx_reg;
        my_next        = my_reg;
        pon_next       = pon_reg;
        res_valid_next = res_valid_reg && !results.ready;
        res_pon_next   = res_pon_reg;
        res_cmd_next   = res_cmd_reg;
        pop            = 1'b0;
        pix_we         = 1'b0;
        tmp_we         = 1'b0;
        clr_all        = 1'b0;
        case (state_reg)
            ST_IDLE:
                if (!q_empty)
                begin
                    pop           = 1'b1;
                    job_next      = q_head;
                    line_idx_next = 2'd0;
                    cnt_next      = 2'd0;
                    pon_next      = 1'b0;
                end
            ST_SETUP:
            begin
                cnt_next = cnt_reg + 2'd1;
                case (cnt_reg)
                    2'd0:
                    begin
                        seg_next = line_sel(job_reg, line_idx_reg);
                        mx_next  = CW'(job_reg.xa);
                        my_next  = CW'(job_reg.ya);
                    end
                    2'd1:    m0_next = prod;
                    2'd2:    m1_next = prod;
                    default:
                    begin
                        // start of a pass
                        m2_next    = prod;
                        merge_next = 1'b0;
                        y_next     = '0;
                        accr_next  = (job_reg.op == OP_LINES) ? (m0_reg - m1_reg)
                                                              : (m0_reg + m1_reg);
                        if (job_reg.op == OP_READ)
                        begin
                            y_next = job_reg.ya[YW-1:0];
                            x_next = job_reg.xa[XW-1:0];
                        end
                        if (job_reg.op == OP_CLR_ALL)
                            clr_all = 1'b1;
                    end
                endcase
            end
            ST_MODW:
            begin
                // reduce the shift amounts into the active area
                if (mx_reg < 0)
                    mx_next = mx_reg + w_s;
                else if (mx_reg >= w_s)
                    mx_next = mx_reg - w_s;
                if (my_reg < 0)
                    my_next = my_reg + h_s;
                else if (my_reg >= h_s)
                    my_next = my_reg - h_s;
                y_next = '0;
                if (job_reg.is_mirror)
                begin
                    xs_next = dir_x ? w_m1 : '0;
                    yd_next = dir_y ? h_m1 : '0;
                end
                else
                begin
                    xs_next = mx_reg[XW-1:0];
                    yd_next = my_reg[YW-1:0];
                end
            end
            ST_ROW_LD:
            begin
                if (job_reg.op == OP_READ)
                    pon_next = row_in[x_reg];
                else if (merge_reg)
                begin
                    for (int i = 0; i < MAX_WIDTH; i++)
                        obuf_next[i] = (i < int'(w_eff)) ? tmp_q[i] : row_in[i];
                end
                else
                begin
                    rbuf_next = row_in;
                    x_next    = '0;
                    acc_next  = accr_reg;
                    xd_next   = xs_reg;
                end
            end
            ST_PIX:
            begin
                x_next = x_reg + 1'b1;
                case (job_reg.op)
                    OP_LINES:
                    begin
                        if (line_hit)
                            rbuf_next[x_reg] = 1'b1;
                        acc_next = acc_reg - AW'(dy);
                    end
                    OP_CIRCLE:
                    begin
                        if (circ_hit)
                            rbuf_next[x_reg] = 1'b1;
                        acc_next = acc_reg + AW'($signed({xs - cx, 1'b1}));
                    end
                    OP_CLR_RECT:
                        if (rect_in)
                            rbuf_next[x_reg] = 1'b0;
                    OP_REMAP:
                    begin
                        obuf_next[xd_reg] = rbuf_reg[x_reg];
                        if (dir_x)
                            xd_next = xd_reg - 1'b1;
                        else
                            xd_next = (xd_reg == w_m1) ? '0 : xd_reg + 1'b1;
                    end
                    default: ;
                endcase
            end
            ST_ROW_WR:
            begin
                y_next = y_reg + 1'b1;
                if (job_reg.op == OP_REMAP && !merge_reg)
                begin
                    tmp_we = 1'b1;
                    if (dir_y)
                        yd_next = yd_reg - 1'b1;
                    else
                        yd_next = (yd_reg == h_m1) ? '0 : yd_reg + 1'b1;
                end
                else
                    pix_we = 1'b1;
                if (job_reg.op == OP_LINES)
                    accr_next = accr_reg + AW'(dx);
                else
                    accr_next = accr_reg + AW'($signed({ys - cy, 1'b1}));
                if (last_y)
                begin
                    y_next        = '0;
                    line_idx_next = line_idx_reg + 2'd1;
                    if (job_reg.op == OP_REMAP)
                        merge_next = 1'b1;
                end
            end
            ST_DONE:
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_pon_next   = pon_reg;
                    res_cmd_next   = job_reg.cmd;
                end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            row_valid_reg <= '0;
            valid_q       <= 1'b0;
            line_idx_reg  <= '0;
            cnt_reg       <= '0;
            merge_reg     <= 1'b0;
            y_reg         <= '0;
            x_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            line_idx_reg  <= line_idx_next;
            cnt_reg       <= cnt_next;
            merge_reg     <= merge_next;
            y_reg         <= y_next;
            x_reg         <= x_next;
            valid_q       <= row_valid_reg[y_reg];
            if (clr_all)
                row_valid_reg <= '0;
            else if (pix_we)
                row_valid_reg[y_reg] <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        job_reg     <= job_next;
        xd_reg      <= xd_next;
        xs_reg      <= xs_next;
        yd_reg      <= yd_next;
        rbuf_reg    <= rbuf_next;
        obuf_reg    <= obuf_next;
        acc_reg     <= acc_next;
        accr_reg    <= accr_next;
        m0_reg      <= m0_next;
        m1_reg      <= m1_next;
        m2_reg      <= m2_next;
        seg_reg     <= seg_next;
        mx_reg      <= mx_next;
        my_reg      <= my_next;
        pon_reg     <= pon_next;
        res_pon_reg <= res_pon_next;
        res_cmd_reg <= res_cmd_next;
    end

    // row memories, registered reads
    always_ff @(posedge clk)
    begin
        if (pix_we)
            pix_mem[y_reg] <= merge_reg ? obuf_reg : rbuf_reg;
        if (tmp_we)
            tmp_mem[yd_reg] <= obuf_reg;
        pix_q <= pix_mem[y_reg];
        tmp_q <= tmp_mem[y_reg];
    end

    assign results.valid    = res_valid_reg;
    assign results.pixel_on = res_pon_reg;
    assign results.cmd_done = res_cmd_reg;

endmodule

[sv/bitmap_draw_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_draw_engine
// One-bit-per-pixel framebuffer engine with draw, clear, shift, mirror, read.
// ----------------------------------------------------------------------------
// Commands arrive on cmds (valid/ready); every command gives exactly one
// transfer on results carrying the read pixel (zero for other commands) and
// the command code. cfg writes active_width (index 0) and active_height
// (index 1); it is always ready, and the user must write it only while the
// engine is idle: the block itself does not enforce this. A two-entry queue
// sits between the command front end and the executor, so up to two further
// commands are taken while one executes. Plot and line draw in one pass over
// the active area, triangle in three passes and rectangle in four; circle and
// clear rectangle take one pass; shift and mirror first reduce the amount
// into the active area, then make a pass into the scratch rows and a merge
// pass; clear all makes no pass. A read outside the active area skips the
// row read. The executor scans the active area one pixel per cycle, with one
// row read and one row write per row.
// Reset clears all pixels at once through per-row valid bits, and restores
// the register defaults. A stalled result receiver holds the finished result
// in the output register; the executor waits until it is taken.
// ----------------------------------------------------------------------------
module bitmap_draw_engine
    import bde_pkg::*;
#(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    bde_cmd_if.sink   cmds,
    bde_res_if.source results,
    bde_cfg_if.sink   cfg
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);

    logic [7:0]  active_width_reg;
    logic [6:0]  active_height_reg;
    logic [XW:0] w_eff;
    logic [YW:0] h_eff;
    logic        q_full, q_empty, push, pop;
    job_t        push_job, head_job;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_width_reg  <= 8'd93;
            active_height_reg <= 7'd43;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_ACTIVE_WIDTH:  active_width_reg  <= cfg.data;
                REG_ACTIVE_HEIGHT: active_height_reg <= cfg.data[6:0];
                default: ;
            endcase
        end
    end

    // saturate to the store size; zero counts as one
    always_comb
    begin
        if (active_width_reg == '0)
            w_eff = (XW + 1)'(1);
        else if (32'(active_width_reg) > MAX_WIDTH)
            w_eff = (XW + 1)'(MAX_WIDTH);
        else
            w_eff = (XW + 1)'(active_width_reg);
        if (active_height_reg == '0)
            h_eff = (YW + 1)'(1);
        else if (32'(active_height_reg) > MAX_HEIGHT)
            h_eff = (YW + 1)'(MAX_HEIGHT);
        else
            h_eff = (YW + 1)'(active_height_reg);
    end

    bde_front u_front (
        .q_full (q_full),
        .cmds   (cmds),
        .push   (push),
        .job    (push_job)
    );

    bde_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .full      (q_full),
        .pop       (pop),
        .empty     (q_empty),
        .head      (head_job)
    );

    bde_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (head_job),
        .pop     (pop),
        .w_eff   (w_eff),
        .h_eff   (h_eff),
        .results (results)
    );

endmodule
